>>> rtl/core/swvg_pkg.sv
package swvg_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_RINGS_DEF    = 255;
    localparam int MAX_SEGMENTS_DEF = 256;
    localparam int ANGLE_BITS_DEF   = 16;

    // Register indexes on the configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RING_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z      = 3'd5;

    localparam logic [30:0] RADIUS_RESET        = 31'd65536;
    localparam int          RING_COUNT_RESET    = 16;
    localparam int          SEGMENT_COUNT_RESET = 32;
    localparam int          COUNT_MIN           = 3;

    // CORDIC constants, Q2.30
    localparam int                 CORDIC_STEPS    = 30;
    localparam int                 CORDIC_LAT      = CORDIC_STEPS + 2;
    localparam logic signed [31:0] CORDIC_GAIN_INV = 32'sd652032874;
    localparam logic [32:0]        TWO_PI_Q30      = 33'd6746518852;
    localparam int                 Q30_HALF        = 536870912;

    localparam logic signed [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
        32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
        32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
        32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
        32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
        32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
        32'sd1024,      32'sd512,       32'sd256,       32'sd128,
        32'sd64,        32'sd32,        32'sd16,        32'sd8,
        32'sd4,         32'sd2
    };

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic        [1:0]  quad;
    } cordic_t;

endpackage

>>> rtl/core/swvg_div_cell.sv
module swvg_div_cell
    import swvg_pkg::*;
#(
    parameter int DW = 9,
    parameter int QB = 17
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [DW-1:0] divisor,
    input  logic [DW-1:0] rem_in,
    input  logic [QB-1:0] bits_in,
    output logic [DW-1:0] rem_out,
    output logic [QB-1:0] bits_out
);

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_next;
    logic [QB-1:0] bits_next;
    logic [DW-1:0] rem_reg;
    logic [QB-1:0] bits_reg;

    // Shift one numerator bit into the remainder, subtract when it fits
    always_comb begin
        trial     = {rem_in, bits_in[QB-1]};
        diff      = trial - {1'b0, divisor};
        ge        = (trial >= {1'b0, divisor});
        rem_next  = ge ? diff[DW-1:0] : trial[DW-1:0];
        bits_next = {bits_in[QB-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            bits_reg <= bits_next;
        end
    end

    assign rem_out  = rem_reg;
    assign bits_out = bits_reg;

endmodule

>>> rtl/core/swvg_cordic_cell.sv
module swvg_cordic_cell
    import swvg_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic    aclk,
    input  logic    en,
    input  cordic_t d_in,
    output cordic_t d_out
);

    logic signed [31:0] dx;
    logic signed [31:0] dy;
    cordic_t            d_next;
    cordic_t            d_reg;

    // Rotate toward zero residual angle
    always_comb begin
        dx          = d_in.y >>> STEP;
        dy          = d_in.x >>> STEP;
        d_next.quad = d_in.quad;
        if (d_in.z >= 0) begin
            d_next.x = d_in.x - dx;
            d_next.y = d_in.y + dy;
            d_next.z = d_in.z - ATAN_Q30[STEP];
        end else begin
            d_next.x = d_in.x + dx;
            d_next.y = d_in.y - dy;
            d_next.z = d_in.z + ATAN_Q30[STEP];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

>>> rtl/core/swvg_sincos.sv
module swvg_sincos
    import swvg_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] phase,
    output logic signed [31:0]    cos_q30,
    output logic signed [31:0]    sin_q30
);

    localparam int RW = ANGLE_BITS - 2;
    localparam int PW = RW + 33;

    logic [PW-1:0]      prod;
    logic [PW:0]        prod_rnd;
    cordic_t            prep_next;
    cordic_t            chain [CORDIC_STEPS+1];
    logic signed [31:0] cos_next;
    logic signed [31:0] sin_next;
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;

    // Quadrant remainder to radians, rounded half up
    always_comb begin
        prod           = PW'(phase[RW-1:0]) * PW'(TWO_PI_Q30);
        prod_rnd       = {1'b0, prod} + ((PW+1)'(1) << (ANGLE_BITS - 1));
        prep_next.x    = CORDIC_GAIN_INV;
        prep_next.y    = '0;
        prep_next.z    = signed'(prod_rnd[ANGLE_BITS +: 32]);
        prep_next.quad = phase[ANGLE_BITS-1 -: 2];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            chain[0] <= prep_next;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        swvg_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .aclk  (aclk),
            .en    (en),
            .d_in  (chain[i]),
            .d_out (chain[i+1])
        );
    end

    // Map back to the full circle
    always_comb begin
        unique case (chain[CORDIC_STEPS].quad)
            2'd0: begin
                cos_next = chain[CORDIC_STEPS].x;
                sin_next = chain[CORDIC_STEPS].y;
            end
            2'd1: begin
                cos_next = -chain[CORDIC_STEPS].y;
                sin_next = chain[CORDIC_STEPS].x;
            end
            2'd2: begin
                cos_next = -chain[CORDIC_STEPS].x;
                sin_next = -chain[CORDIC_STEPS].y;
            end
            default: begin
                cos_next = chain[CORDIC_STEPS].y;
                sin_next = -chain[CORDIC_STEPS].x;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_q30 = cos_reg;
    assign sin_q30 = sin_reg;

endmodule

>>> rtl/core/sphere_wire_vertex_generator_core.sv
// Wire-sphere vertex generator. Each transfer on the s_ channel names one grid
// point (ring, segment) of a latitude/longitude sphere; one transfer on the m_
// channel returns its Q16.16 position (center plus radius times sin/cos of
// latitude and longitude, saturated to 32 bits), its linear index, the index of
// the next vertex around the ring, the index of the same segment one ring up
// with a flag that this edge exists, and an error flag for indices beyond the
// configured counts (all other fields then read zero). The block takes one
// vertex every cycle and returns one every cycle. Its stages are the two rows
// of ANGLE_BITS+1 divider cells that turn indices into phases, the 30 CORDIC
// cells per angle between their input and output registers, and the two
// rounding multiplies plus the saturating output stage. The whole chain
// advances together and holds while the output register is full and not taken.
// Write configuration only when no vertex is in flight; ring and segment counts
// below 3 are stored as 3 and counts above the maximum as the maximum.
module sphere_wire_vertex_generator_core
    import swvg_pkg::*;
#(
    parameter int MAX_RINGS    = MAX_RINGS_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_ring_index,
    input  logic [7:0]           s_segment_index,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_pos_x,
    output logic signed [31:0]   m_pos_y,
    output logic signed [31:0]   m_pos_z,
    output logic [15:0]          m_vertex_index,
    output logic [15:0]          m_around_index,
    output logic [15:0]          m_upward_index,
    output logic                 m_has_upward_edge,
    output logic                 m_index_error
);

    localparam int RCW = $clog2(MAX_RINGS + 1);
    localparam int SCW = $clog2(MAX_SEGMENTS + 1);
    localparam int DWR = $clog2(2 * MAX_RINGS + 1);
    localparam int DWS = $clog2(2 * MAX_SEGMENTS + 1);
    localparam int QB  = ANGLE_BITS + 1;
    localparam int NW  = QB + 8;
    localparam int LAT = QB + CORDIC_LAT + 3;
    localparam int IW  = 8 + SCW + 1;
    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [30:0]        radius_reg;
    logic [RCW-1:0]     ring_count_reg;
    logic [SCW-1:0]     segment_count_reg;
    logic signed [31:0] center_x_reg;
    logic signed [31:0] center_y_reg;
    logic signed [31:0] center_z_reg;
    logic [RCW-1:0]     ring_count_next;
    logic [SCW-1:0]     segment_count_next;

    // Clamp counts into the supported range
    always_comb begin
        if (cfg_data[7:0] < 8'(COUNT_MIN)) begin
            ring_count_next = RCW'(COUNT_MIN);
        end else if (int'(cfg_data[7:0]) > MAX_RINGS) begin
            ring_count_next = RCW'(MAX_RINGS);
        end else begin
            ring_count_next = RCW'(cfg_data[7:0]);
        end
        if (cfg_data[8:0] < 9'(COUNT_MIN)) begin
            segment_count_next = SCW'(COUNT_MIN);
        end else if (int'(cfg_data[8:0]) > MAX_SEGMENTS) begin
            segment_count_next = SCW'(MAX_SEGMENTS);
        end else begin
            segment_count_next = SCW'(cfg_data[8:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg        <= RADIUS_RESET;
            ring_count_reg    <= RCW'(RING_COUNT_RESET);
            segment_count_reg <= SCW'(SEGMENT_COUNT_RESET);
            center_x_reg      <= '0;
            center_y_reg      <= '0;
            center_z_reg      <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_RADIUS:        radius_reg        <= cfg_data[30:0];
                REG_RING_COUNT:    ring_count_reg    <= ring_count_next;
                REG_SEGMENT_COUNT: segment_count_reg <= segment_count_next;
                REG_CENTER_X:      center_x_reg      <= signed'(cfg_data);
                REG_CENTER_Y:      center_y_reg      <= signed'(cfg_data);
                REG_CENTER_Z:      center_z_reg      <= signed'(cfg_data);
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances together
    // ------------------------------------------------------------------
    logic            adv;
    logic [LAT-1:0]  vld_reg;
    logic [15:0]     tag_reg [LAT-1];

    assign adv     = !vld_reg[LAT-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // Carry the indices alongside the datapath
    always_ff @(posedge aclk) begin
        if (adv) begin
            tag_reg[0] <= {s_ring_index, s_segment_index};
            for (int k = 1; k < LAT - 1; k++) begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Phases: lat = round(ring*2^A / (2*rings)), lon = round(seg*2^A / segs)
    // Each row is a chain of restoring-division cells, one quotient bit each.
    // ------------------------------------------------------------------
    logic [NW-1:0]  n_lat;
    logic [NW-1:0]  n_lon;
    logic [DWR-1:0] lat_div;
    logic [DWS-1:0] lon_div;
    logic [DWR-1:0] lat_rem  [QB+1];
    logic [QB-1:0]  lat_bits [QB+1];
    logic [DWS-1:0] lon_rem  [QB+1];
    logic [QB-1:0]  lon_bits [QB+1];

    always_comb begin
        n_lat       = (NW'(s_ring_index) << ANGLE_BITS) + NW'(ring_count_reg);
        n_lon       = (NW'(s_segment_index) << QB) + NW'(segment_count_reg);
        lat_div     = DWR'({ring_count_reg, 1'b0});
        lon_div     = DWS'({segment_count_reg, 1'b0});
        lat_rem[0]  = DWR'(n_lat >> QB);
        lat_bits[0] = n_lat[QB-1:0];
        lon_rem[0]  = DWS'(n_lon >> QB);
        lon_bits[0] = n_lon[QB-1:0];
    end

    for (genvar i = 0; i < QB; i++) begin : g_div
        swvg_div_cell #(
            .DW (DWR),
            .QB (QB)
        ) u_lat_cell (
            .aclk     (aclk),
            .en       (adv),
            .divisor  (lat_div),
            .rem_in   (lat_rem[i]),
            .bits_in  (lat_bits[i]),
            .rem_out  (lat_rem[i+1]),
            .bits_out (lat_bits[i+1])
        );
        swvg_div_cell #(
            .DW (DWS),
            .QB (QB)
        ) u_lon_cell (
            .aclk     (aclk),
            .en       (adv),
            .divisor  (lon_div),
            .rem_in   (lon_rem[i]),
            .bits_in  (lon_bits[i]),
            .rem_out  (lon_rem[i+1]),
            .bits_out (lon_bits[i+1])
        );
    end

    // Latitude starts at the south pole: subtract a quarter turn
    logic [ANGLE_BITS-1:0] lat_phase;
    logic [ANGLE_BITS-1:0] lon_phase;

    assign lat_phase = lat_bits[QB][ANGLE_BITS-1:0] - QUARTER_TURN;
    assign lon_phase = lon_bits[QB][ANGLE_BITS-1:0];

    logic signed [31:0] cos_lat;
    logic signed [31:0] sin_lat;
    logic signed [31:0] cos_lon;
    logic signed [31:0] sin_lon;

    swvg_sincos #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_lat_sincos (
        .aclk    (aclk),
        .en      (adv),
        .phase   (lat_phase),
        .cos_q30 (cos_lat),
        .sin_q30 (sin_lat)
    );

    swvg_sincos #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_lon_sincos (
        .aclk    (aclk),
        .en      (adv),
        .phase   (lon_phase),
        .cos_q30 (cos_lon),
        .sin_q30 (sin_lon)
    );

    // ------------------------------------------------------------------
    // First multiply: ring radius and y offset, rounded half up
    // ------------------------------------------------------------------
    logic signed [31:0] radius_s;
    logic signed [63:0] rr_rnd;
    logic signed [63:0] yo_rnd;
    logic signed [33:0] ring_r_reg;
    logic signed [33:0] y_off_reg;
    logic signed [31:0] cos_lon_reg;
    logic signed [31:0] sin_lon_reg;

    always_comb begin
        radius_s = signed'({1'b0, radius_reg});
        rr_rnd   = 64'(radius_s * cos_lat) + 64'(Q30_HALF);
        yo_rnd   = 64'(radius_s * sin_lat) + 64'(Q30_HALF);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ring_r_reg  <= rr_rnd[63:30];
            y_off_reg   <= yo_rnd[63:30];
            cos_lon_reg <= cos_lon;
            sin_lon_reg <= sin_lon;
        end
    end

    // ------------------------------------------------------------------
    // Second multiply: x and z offsets
    // ------------------------------------------------------------------
    logic signed [65:0] xo_rnd;
    logic signed [65:0] zo_rnd;
    logic signed [35:0] x_off_reg;
    logic signed [35:0] z_off_reg;
    logic signed [33:0] y_off_d_reg;

    always_comb begin
        xo_rnd = 66'(ring_r_reg * cos_lon_reg) + 66'(Q30_HALF);
        zo_rnd = 66'(ring_r_reg * sin_lon_reg) + 66'(Q30_HALF);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_off_reg   <= xo_rnd[65:30];
            z_off_reg   <= zo_rnd[65:30];
            y_off_d_reg <= y_off_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: center sums with saturation, indices, error check
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > 37'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -37'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic [7:0]         ring_t;
    logic [7:0]         seg_t;
    logic               err;
    logic               up_ok;
    logic [IW-1:0]      row_base;
    logic [IW-1:0]      vidx;
    logic signed [36:0] sum_x;
    logic signed [36:0] sum_y;
    logic signed [36:0] sum_z;

    logic signed [31:0] pos_x_next;
    logic signed [31:0] pos_y_next;
    logic signed [31:0] pos_z_next;
    logic [15:0]        vertex_next;
    logic [15:0]        around_next;
    logic [15:0]        upward_next;

    logic signed [31:0] pos_x_reg;
    logic signed [31:0] pos_y_reg;
    logic signed [31:0] pos_z_reg;
    logic [15:0]        vertex_reg;
    logic [15:0]        around_reg;
    logic [15:0]        upward_reg;
    logic               has_up_reg;
    logic               err_reg;

    always_comb begin
        ring_t   = tag_reg[LAT-2][15:8];
        seg_t    = tag_reg[LAT-2][7:0];
        err      = (IW'(ring_t) > IW'(ring_count_reg)) ||
                   (IW'(seg_t) >= IW'(segment_count_reg));
        up_ok    = IW'(ring_t) < IW'(ring_count_reg);
        row_base = IW'(ring_t) * IW'(segment_count_reg);
        vidx     = row_base + IW'(seg_t);
        sum_x    = 37'(x_off_reg) + 37'(center_x_reg);
        sum_y    = 37'(y_off_d_reg) + 37'(center_y_reg);
        sum_z    = 37'(z_off_reg) + 37'(center_z_reg);

        pos_x_next  = '0;
        pos_y_next  = '0;
        pos_z_next  = '0;
        vertex_next = '0;
        around_next = '0;
        upward_next = '0;
        if (!err) begin
            pos_x_next  = sat32(sum_x);
            pos_y_next  = sat32(sum_y);
            pos_z_next  = sat32(sum_z);
            vertex_next = 16'(vidx);
            // wrap the last segment back to the start of the ring
            if (IW'(seg_t) + IW'(1) == IW'(segment_count_reg)) begin
                around_next = 16'(row_base);
            end else begin
                around_next = 16'(vidx + IW'(1));
            end
            if (up_ok) begin
                upward_next = 16'(vidx + IW'(segment_count_reg));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            pos_z_reg  <= pos_z_next;
            vertex_reg <= vertex_next;
            around_reg <= around_next;
            upward_reg <= upward_next;
            has_up_reg <= up_ok && !err;
            err_reg    <= err;
        end
    end

    assign m_pos_x           = pos_x_reg;
    assign m_pos_y           = pos_y_reg;
    assign m_pos_z           = pos_z_reg;
    assign m_vertex_index    = vertex_reg;
    assign m_around_index    = around_reg;
    assign m_upward_index    = upward_reg;
    assign m_has_upward_edge = has_up_reg;
    assign m_index_error     = err_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_index_error |-> m_pos_x == 0 && m_pos_y == 0 && m_pos_z == 0 &&
            m_vertex_index == 0 && m_around_index == 0 && !m_has_upward_edge)
        else $error("error transfer carries nonzero fields");

    a_top_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_upward_edge |-> m_upward_index == 0)
        else $error("upward index set without upward edge");

    a_around: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_index_error |-> m_around_index != m_vertex_index)
        else $error("around index equals vertex index");

endmodule

>>> verif/sphere_wire_vertex_generator_core_tb.sv
module sphere_wire_vertex_generator_core_tb;
    import swvg_pkg::*;

    localparam int  ANGLE_W     = ANGLE_BITS_DEF;
    localparam int  LATENCY     = ANGLE_BITS_DEF + 36;
    localparam int  STALL_LIMIT = 4000;
    localparam int  MAX_RING_C  = MAX_RINGS_DEF;
    localparam int  MAX_SEG_C   = MAX_SEGMENTS_DEF;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    // One expected vertex record, laid out like the m_ channel
    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [15:0]        vertex_index;
        logic [15:0]        around_index;
        logic [15:0]        upward_index;
        logic               has_upward_edge;
        logic               index_error;
    } vertex_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_ring_index;
    logic [7:0]           s_segment_index;
    logic                 m_valid;
    logic                 m_ready;
    logic signed [31:0]   m_pos_x;
    logic signed [31:0]   m_pos_y;
    logic signed [31:0]   m_pos_z;
    logic [15:0]          m_vertex_index;
    logic [15:0]          m_around_index;
    logic [15:0]          m_upward_index;
    logic                 m_has_upward_edge;
    logic                 m_index_error;

    // Shadow copy of the sphere geometry registers
    logic [30:0]          geo_radius;
    int unsigned          geo_rings;
    int unsigned          geo_segs;
    logic signed [63:0]   geo_cx;
    logic signed [63:0]   geo_cy;
    logic signed [63:0]   geo_cz;

    vertex_t              pending_vertices[$];
    int                   mismatch_count;
    int                   sent_count;
    int                   got_count;
    int                   error_count;
    int                   idle_cycles;
    bit                   stim_done;

    sphere_wire_vertex_generator_core i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_ring_index      (s_ring_index),
        .s_segment_index   (s_segment_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pos_x           (m_pos_x),
        .m_pos_y           (m_pos_y),
        .m_pos_z           (m_pos_z),
        .m_vertex_index    (m_vertex_index),
        .m_around_index    (m_around_index),
        .m_upward_index    (m_upward_index),
        .m_has_upward_edge (m_has_upward_edge),
        .m_index_error     (m_index_error)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Floor divide by 2^n for signed values
    function automatic logic signed [63:0] floor_div_pow2(logic signed [63:0] v, int n);
        return v >>> n;
    endfunction

    function automatic logic signed [63:0] round_q30_product(logic signed [63:0] a,
                                                             logic signed [63:0] b);
        return floor_div_pow2(a * b + 64'sd536870912, 30);
    endfunction

    function automatic logic signed [31:0] clip_to_32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Rotation CORDIC over one quadrant, then map the quadrant back
    task automatic phase_sin_cos(input logic [63:0] phase,
                                 output logic signed [63:0] c,
                                 output logic signed [63:0] s);
        logic [1:0]         quad;
        logic [63:0]        rest;
        logic signed [63:0] x, y, z, dx, dy;
        quad = phase[ANGLE_W-1 -: 2];
        rest = phase & ((64'd1 << (ANGLE_W - 2)) - 1);
        z = (rest * 64'd6746518852 + (64'd1 << (ANGLE_W - 1))) >> ANGLE_W;
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = floor_div_pow2(y, i);
            dy = floor_div_pow2(x, i);
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - ATAN_Q30[i];
            end else begin
                x = x + dx; y = y - dy; z = z + ATAN_Q30[i];
            end
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    task automatic predict_vertex(input logic [7:0] ring, input logic [7:0] seg,
                                  output vertex_t v);
        logic [63:0]        full, lat_ph, lon_ph;
        logic signed [63:0] clat, slat, clon, slon, ring_r;
        full = 64'd1 << ANGLE_W;
        v = '{default: '0};
        if (ring > geo_rings || seg >= geo_segs) begin
            v.index_error = 1'b1;
            return;
        end
        lat_ph = (ring * full + geo_rings) / (2 * geo_rings);
        lat_ph = (lat_ph + full - (full >> 2)) & (full - 1);
        lon_ph = ((seg * full * 2 + geo_segs) / (2 * geo_segs)) & (full - 1);
        phase_sin_cos(lat_ph, clat, slat);
        phase_sin_cos(lon_ph, clon, slon);
        ring_r  = round_q30_product({33'd0, geo_radius}, clat);
        v.pos_x = clip_to_32(geo_cx + round_q30_product(ring_r, clon));
        v.pos_y = clip_to_32(geo_cy + round_q30_product({33'd0, geo_radius}, slat));
        v.pos_z = clip_to_32(geo_cz + round_q30_product(ring_r, slon));
        v.vertex_index = 16'(ring * geo_segs + seg);
        v.around_index = 16'(ring * geo_segs + (seg + 1) % geo_segs);
        if (ring < geo_rings) begin
            v.upward_index    = 16'((ring + 1) * geo_segs + seg);
            v.has_upward_edge = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("MISMATCH %s: got %0h want %0h (result %0d)", what, got, want, got_count);
    endtask

    // Write one register and mirror it in the shadow copy, clamping counts
    task automatic write_geometry(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_RADIUS:        geo_radius = data[30:0];
            REG_RING_COUNT:    geo_rings = (data[7:0] < COUNT_MIN) ? COUNT_MIN :
                                           (data[7:0] > MAX_RING_C) ? MAX_RING_C : data[7:0];
            REG_SEGMENT_COUNT: geo_segs = (data[8:0] < COUNT_MIN) ? COUNT_MIN :
                                          (data[8:0] > MAX_SEG_C) ? MAX_SEG_C : data[8:0];
            REG_CENTER_X:      geo_cx = $signed(data);
            REG_CENTER_Y:      geo_cy = $signed(data);
            REG_CENTER_Z:      geo_cz = $signed(data);
            default: ;
        endcase
    endtask

    // Send one grid point; hold valid and payload until the transfer.
    // Valid drops only when a gap follows, so back-to-back items keep it high.
    task automatic send_vertex(input logic [7:0] ring, input logic [7:0] seg, input bit gaps);
        vertex_t v;
        int      gap;
        gap = gaps ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        predict_vertex(ring, seg, v);
        pending_vertices = {pending_vertices, v};
        s_valid         <= 1'b1;
        s_ring_index    <= ring;
        s_segment_index <= seg;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    // Wait for the pipeline to drain before touching registers
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // Random vertices, mostly in range, some past the counts
    task automatic random_vertices(input int n, input bit gaps);
        logic [7:0] r, sg;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 8) begin
                r  = 8'($urandom_range(0, geo_rings));
                sg = 8'($urandom_range(0, geo_segs - 1));
            end else begin
                r  = 8'($urandom);
                sg = 8'($urandom);
            end
            send_vertex(r, sg, gaps);
        end
    endtask

    task automatic test_reset_defaults();
        send_vertex(8'd0, 8'd0, 1'b0);
        send_vertex(8'd16, 8'd31, 1'b0);
        send_vertex(8'd8, 8'd8, 1'b0);
        send_vertex(8'd17, 8'd0, 1'b0);
        send_vertex(8'd0, 8'd32, 1'b0);
        send_vertex(8'd255, 8'd255, 1'b0);
        drain_pipeline();
    endtask

    // Smallest sphere: counts written below the floor clamp to three
    task automatic test_minimum_counts();
        write_geometry(REG_RING_COUNT, 32'd0);
        write_geometry(REG_SEGMENT_COUNT, 32'd1);
        for (int r = 0; r <= 4; r++)
            for (int sg = 0; sg <= 3; sg++) send_vertex(8'(r), 8'(sg), 1'b0);
        drain_pipeline();
    endtask

    // Largest sphere, top indices, and saturation at both extremes
    task automatic test_extremes_and_saturation();
        write_geometry(REG_RING_COUNT, 32'd255);
        write_geometry(REG_SEGMENT_COUNT, 32'h1ff);
        write_geometry(REG_RADIUS, 32'hffffffff);
        write_geometry(REG_CENTER_X, 32'h7fffffff);
        write_geometry(REG_CENTER_Y, 32'h80000000);
        write_geometry(REG_CENTER_Z, 32'h7fff0000);
        send_vertex(8'd255, 8'd255, 1'b0);
        send_vertex(8'd0, 8'd128, 1'b0);
        send_vertex(8'd128, 8'd0, 1'b0);
        send_vertex(8'd127, 8'd64, 1'b0);
        send_vertex(8'd64, 8'd192, 1'b0);
        random_vertices(150, 1'b1);
        drain_pipeline();
    endtask

    // Random geometry per phase, random traffic with gaps in phases where p % 3 != 1
    task automatic test_random_geometry();
        for (int p = 0; p < 10; p++) begin
            write_geometry(REG_RADIUS, (p % 3 == 0) ? $urandom_range(0, 32'h0008_0000) : $urandom);
            write_geometry(REG_RING_COUNT, $urandom_range(0, 255));
            write_geometry(REG_SEGMENT_COUNT, (p % 4 == 0) ? 32'h100 : $urandom_range(0, 511));
            write_geometry(REG_CENTER_X, $urandom);
            write_geometry(REG_CENTER_Y, (p % 2) ? $urandom : $urandom_range(0, 32'h10000));
            write_geometry(REG_CENTER_Z, $urandom);
            write_geometry(REG_UNMAPPED, $urandom);  // unused index, must be ignored
            random_vertices(160, p % 3 != 1);
            drain_pipeline();
        end
    endtask

    // Compare each m_ transfer with the oldest expected vertex
    always @(posedge aclk) begin
        vertex_t w;
        if (aresetn && m_valid && m_ready) begin
            got_count++;
            if (pending_vertices.size() == 0) begin
                report_mismatch("unexpected vertex", m_vertex_index, 0);
            end else begin
                w = pending_vertices.pop_front();
                if (w.index_error) error_count++;
                if (m_pos_x !== w.pos_x) report_mismatch("pos_x", m_pos_x, w.pos_x);
                if (m_pos_y !== w.pos_y) report_mismatch("pos_y", m_pos_y, w.pos_y);
                if (m_pos_z !== w.pos_z) report_mismatch("pos_z", m_pos_z, w.pos_z);
                if (m_vertex_index !== w.vertex_index)
                    report_mismatch("vertex_index", m_vertex_index, w.vertex_index);
                if (m_around_index !== w.around_index)
                    report_mismatch("around_index", m_around_index, w.around_index);
                if (m_upward_index !== w.upward_index)
                    report_mismatch("upward_index", m_upward_index, w.upward_index);
                if (m_has_upward_edge !== w.has_upward_edge)
                    report_mismatch("has_upward_edge", m_has_upward_edge, w.has_upward_edge);
                if (m_index_error !== w.index_error)
                    report_mismatch("index_error", m_index_error, w.index_error);
            end
        end
    end

    // Receiver: draw a stall per result, with stretches of none
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if ((got_count / 200) % 2 == 1) stall = 0;
            repeat (stall) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Watchdog: end the run when nothing transfers for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int tail;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        s_valid         = 1'b0;
        s_ring_index    = '0;
        s_segment_index = '0;
        aresetn         = 1'b0;
        mismatch_count  = 0;
        sent_count      = 0;
        got_count       = 0;
        error_count     = 0;
        idle_cycles     = 0;
        stim_done       = 0;
        geo_radius      = RADIUS_RESET;
        geo_rings       = RING_COUNT_RESET;
        geo_segs        = SEGMENT_COUNT_RESET;
        geo_cx          = 0;
        geo_cy          = 0;
        geo_cz          = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_minimum_counts();
        test_extremes_and_saturation();
        test_random_geometry();

        // Final wait: drain, then a bounded tail
        tail = 0;
        while (pending_vertices.size() != 0 && tail < 20 * STALL_LIMIT) begin
            @(posedge aclk);
            tail++;
        end
        stim_done = 1;
        repeat (LATENCY + 8) @(posedge aclk);
        $display("covered %0d vertices over 13 geometry settings, %0d out-of-range",
                 sent_count, error_count);
        if (mismatch_count == 0 && pending_vertices.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sphere_wire_vertex_generator_core.f
rtl/core/swvg_pkg.sv
rtl/core/swvg_div_cell.sv
rtl/core/swvg_cordic_cell.sv
rtl/core/swvg_sincos.sv
rtl/core/sphere_wire_vertex_generator_core.sv
verif/sphere_wire_vertex_generator_core_tb.sv
